@@ rtl/pbps_pkg.sv @@
`default_nettype none

package pbps_pkg;

    // Remote command carried with each tick
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ON    = 2'd1,
        OP_OFF   = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_OFF_HOLD   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_PULSE      = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W   = 16;
    localparam int HOLD_CFG_W   = 16;
    localparam int PULSE_CFG_W  = 8;

    localparam logic [HOLD_CFG_W-1:0]  OFF_HOLD_RST   = 16'd3000;
    localparam logic [HOLD_CFG_W-1:0]  LONG_PRESS_RST = 16'd500;
    localparam logic [PULSE_CFG_W-1:0] PULSE_RST      = 8'd50;

    // Pulse slots
    localparam int PULSE_COUNT = 3;
    localparam int P_RESET     = 0;
    localparam int P_OSD       = 1;
    localparam int P_USER      = 2;

    typedef struct packed {
        t_op  op;
        logic power_level;
        logic rotary_level;
        logic phones_in;
    } t_in_item;

    typedef struct packed {
        logic power_enable;
        logic green_led;
        logic amber_led;
        logic amp_active;
        logic amp_single_ended;
        logic reset_pulse;
        logic osd_pulse;
        logic user_pulse;
        logic turned_on;
        logic turned_off;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

endpackage

`default_nettype wire

@@ rtl/pbps_chan_if.sv @@
`default_nettype none

interface pbps_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/power_button_pulse_sequencer_core.sv @@
// A result appears in the output register in the cycle after its tick is transferred.
// Throughput: one tick per cycle unless the sink holds a result back; all state updates in
// one pass of flag and counter logic. The output register frees as its result is taken, so
// input and output stall together only when a result is held back by the sink.
// Reset (synchronous, active low): power off, timers and pulses cleared, single-ended set,
// configuration back to 3000 / 500 / 50 ms, no result pending.
`default_nettype none

module power_button_pulse_sequencer_core
    import pbps_pkg::*;
#(
    parameter int TIMER_WIDTH       = 16,
    parameter int PULSE_TIMER_WIDTH = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pbps_chan_if.sink    i_cfg,
    pbps_chan_if.sink    i_in,
    pbps_chan_if.source  o_out
);

    // Compare widths wide enough for both the timer and its threshold
    localparam int HCMP_W = (TIMER_WIDTH > HOLD_CFG_W) ? TIMER_WIDTH : HOLD_CFG_W;
    localparam int PCMP_W = (PULSE_TIMER_WIDTH > PULSE_CFG_W) ? PULSE_TIMER_WIDTH : PULSE_CFG_W;

    localparam logic [TIMER_WIDTH-1:0]       HOLD_MAX  = '1;
    localparam logic [PULSE_TIMER_WIDTH-1:0] PULSE_MAX = '1;

    // ---------------------------------------------------------------------
    // Configuration registers: always ready; unenforced user rule: write only while idle
    // ---------------------------------------------------------------------
    logic [HOLD_CFG_W-1:0]  r_off_hold_ms;
    logic [HOLD_CFG_W-1:0]  r_long_press_ms;
    logic [PULSE_CFG_W-1:0] r_pulse_ms;
    t_cfg_item              w_cfg;

    assign i_cfg.ready = 1'b1;
    assign w_cfg       = i_cfg.payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_hold_ms   <= OFF_HOLD_RST;
            r_long_press_ms <= LONG_PRESS_RST;
            r_pulse_ms      <= PULSE_RST;
        end else if (i_cfg.valid) begin
            unique case (w_cfg.index)
                CFG_OFF_HOLD:   r_off_hold_ms   <= w_cfg.data[HOLD_CFG_W-1:0];
                CFG_LONG_PRESS: r_long_press_ms <= w_cfg.data[HOLD_CFG_W-1:0];
                CFG_PULSE:      r_pulse_ms      <= w_cfg.data[PULSE_CFG_W-1:0];
                default: ;      // unused index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: accept a tick whenever the output register is free or
    // is being emptied in this cycle
    // ---------------------------------------------------------------------
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      w_out_ready;
    logic      w_accept;
    t_in_item  w_in;

    assign w_out_ready = o_out.ready;
    assign i_in.ready  = !r_out_valid || w_out_ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_in        = i_in.payload;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_data;

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    logic                         r_power_on,      n_power_on;
    logic                         r_await_release, n_await_release;
    logic                         r_long_held,     n_long_held;
    logic                         r_prev_pwr,      n_prev_pwr;
    logic                         r_prev_rot,      n_prev_rot;
    logic [TIMER_WIDTH-1:0]       r_hold_timer,    n_hold_timer;
    logic [PULSE_COUNT-1:0]       r_pulse_active,  n_pulse_active;
    logic [PULSE_TIMER_WIDTH-1:0] r_pulse_elapsed [PULSE_COUNT];
    logic [PULSE_TIMER_WIDTH-1:0] n_pulse_elapsed [PULSE_COUNT];
    logic                         r_single_ended,  n_single_ended;

    logic w_pwr_press;
    logic w_pwr_release;
    logic w_rot_press;
    logic w_cmd_on;
    logic w_off_reached;
    logic w_long_reached;

    assign w_pwr_press   = w_in.power_level && !r_prev_pwr;
    assign w_pwr_release = !w_in.power_level && r_prev_pwr;
    assign w_rot_press   = w_in.rotary_level && !r_prev_rot;

    always_comb begin
        // Apply the remote command first
        unique case (w_in.op)
            OP_ON:   w_cmd_on = 1'b1;
            OP_OFF:  w_cmd_on = 1'b0;
            default: w_cmd_on = r_power_on;   // plain tick and spare code
        endcase

        // Advance running pulse timers, saturating
        n_pulse_active = r_pulse_active;
        for (int k = 0; k < PULSE_COUNT; k++) begin
            if (r_pulse_active[k] && (r_pulse_elapsed[k] != PULSE_MAX)) begin
                n_pulse_elapsed[k] = r_pulse_elapsed[k] + 1'b1;
            end else begin
                n_pulse_elapsed[k] = r_pulse_elapsed[k];
            end
        end

        // Hold timer: clear on release and on the press tick, else count and saturate
        priority if (!w_in.power_level || w_pwr_press) begin
            n_hold_timer = '0;
        end else if (r_hold_timer != HOLD_MAX) begin
            n_hold_timer = r_hold_timer + 1'b1;
        end else begin
            n_hold_timer = r_hold_timer;
        end
        n_prev_pwr = w_in.power_level;
        n_prev_rot = w_in.rotary_level;

        w_off_reached  = HCMP_W'(n_hold_timer) >= HCMP_W'(r_off_hold_ms);
        w_long_reached = HCMP_W'(n_hold_timer) >= HCMP_W'(r_long_press_ms);

        // Power button logic
        n_power_on      = w_cmd_on;
        n_await_release = r_await_release;
        n_long_held     = r_long_held;
        if (r_await_release) begin
            // hold until the button is let go; keep the long-press flag
            n_await_release = w_in.power_level;
        end else begin
            if (w_cmd_on) begin
                if (w_in.power_level && w_off_reached) begin
                    n_power_on      = 1'b0;
                    n_await_release = 1'b1;
                end else if (w_pwr_release) begin
                    if (r_long_held) begin
                        n_pulse_active[P_RESET]  = 1'b1;
                        n_pulse_elapsed[P_RESET] = '0;
                    end else begin
                        n_pulse_active[P_USER]  = 1'b1;
                        n_pulse_elapsed[P_USER] = '0;
                    end
                end
            end else if (w_pwr_press) begin
                n_power_on      = 1'b1;
                n_await_release = 1'b1;
            end
            n_long_held = w_in.power_level && w_long_reached;
        end

        // End expired pulses; the counter ceiling ends a pulse too
        for (int k = 0; k < PULSE_COUNT; k++) begin
            if (n_pulse_active[k] &&
                ((PCMP_W'(n_pulse_elapsed[k]) > PCMP_W'(r_pulse_ms)) ||
                 (n_pulse_elapsed[k] == PULSE_MAX))) begin
                n_pulse_active[k]  = 1'b0;
                n_pulse_elapsed[k] = '0;
            end
        end

        // Rotary press and headphone follow only while on
        n_single_ended = r_single_ended;
        if (n_power_on) begin
            if (w_rot_press) begin
                n_pulse_active[P_OSD]  = 1'b1;
                n_pulse_elapsed[P_OSD] = '0;
            end
            n_single_ended = w_in.phones_in;
        end

        n_out_data.power_enable     = n_power_on;
        n_out_data.green_led        = n_power_on;
        n_out_data.amber_led        = !n_power_on;
        n_out_data.amp_active       = n_power_on;
        n_out_data.amp_single_ended = n_single_ended;
        n_out_data.reset_pulse      = n_pulse_active[P_RESET];
        n_out_data.osd_pulse        = n_pulse_active[P_OSD];
        n_out_data.user_pulse       = n_pulse_active[P_USER];
        n_out_data.turned_on        = !r_power_on && n_power_on;
        n_out_data.turned_off       = r_power_on && !n_power_on;
    end

    // Commit state on each transferred tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_on      <= 1'b0;
            r_await_release <= 1'b0;
            r_long_held     <= 1'b0;
            r_prev_pwr      <= 1'b0;
            r_prev_rot      <= 1'b0;
            r_hold_timer    <= '0;
            r_pulse_active  <= '0;
            for (int k = 0; k < PULSE_COUNT; k++) begin
                r_pulse_elapsed[k] <= '0;
            end
            r_single_ended  <= 1'b1;
        end else if (w_accept) begin
            r_power_on      <= n_power_on;
            r_await_release <= n_await_release;
            r_long_held     <= n_long_held;
            r_prev_pwr      <= n_prev_pwr;
            r_prev_rot      <= n_prev_rot;
            r_hold_timer    <= n_hold_timer;
            r_pulse_active  <= n_pulse_active;
            for (int k = 0; k < PULSE_COUNT; k++) begin
                r_pulse_elapsed[k] <= n_pulse_elapsed[k];
            end
            r_single_ended  <= n_single_ended;
        end
    end

    // Output register: load on transfer in, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (w_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbps_checker.sv @@
`default_nettype none

module pbps_checker
    import pbps_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input t_out_item i_out_data
);

    // Power, LED and amplifier enables always agree
    a_power_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.green_led == i_out_data.power_enable) &&
                        (i_out_data.amp_active == i_out_data.power_enable) &&
                        (i_out_data.amber_led != i_out_data.power_enable))
        else $error("power outputs disagree");

    // Events never both fire, and match the power state they lead to
    a_event_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.turned_on && i_out_data.turned_off) &&
                        (!i_out_data.turned_on || i_out_data.power_enable) &&
                        (!i_out_data.turned_off || !i_out_data.power_enable))
        else $error("on/off event inconsistent with power state");

    // Power-on event needs off state in the result before it, once that was taken
    a_on_after_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_data.power_enable) ##1
        (i_out_valid && i_out_data.turned_on) |-> 1'b0)
        else $error("power-on event while already on");

    // Stalled result holds
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Nothing pending after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind power_button_pulse_sequencer_core pbps_checker u_pbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (r_out_valid),
    .i_out_ready (w_out_ready),
    .i_out_data  (r_out_data)
);

`default_nettype wire
